/* design/weighted_histogram_accumulator_top_assert.svh */
// Assertion macros shared by the weighted histogram accumulator modules.
`ifndef WEIGHTED_HISTOGRAM_ACCUMULATOR_TOP_ASSERT_SVH
`define WEIGHTED_HISTOGRAM_ACCUMULATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define WHA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("weighted histogram assertion failed");
`define WHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("weighted histogram assertion failed");
`else
`define WHA_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define WHA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* design/wha_pkg.sv */
// Types and constants shared by the weighted histogram accumulator modules.
package wha_pkg;

    localparam int MAX_BINS    = 256;
    localparam int BIN_W       = 8;
    localparam int COUNT_W     = 9;
    localparam int VALUE_W     = 32;
    localparam int PROD_W      = 64;
    localparam int TOTAL_W     = 48;
    localparam int CFG_INDEX_W = 2;

    typedef logic [1:0] status_t;
    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_DROPPED   = 2'd1;
    localparam status_t STATUS_BAD_INDEX = 2'd2;

    localparam logic OP_ACCUMULATE = 1'b0;
    localparam logic OP_READ       = 1'b1;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    localparam cfg_index_t CFG_RANGE_MINIMUM     = 2'd0;
    localparam cfg_index_t CFG_INVERSE_BIN_WIDTH = 2'd1;
    localparam cfg_index_t CFG_BINS_IN_USE       = 2'd2;

    typedef struct packed {
        logic               opcode;
        status_t            status;
        logic [BIN_W-1:0]   bin;
        logic [VALUE_W-1:0] weight;
    } bin_req_t;

    typedef struct packed {
        status_t                     status;
        logic [BIN_W-1:0]            bin;
        logic signed [TOTAL_W-1:0]   total;
    } bin_result_t;

endpackage

/* design/wha_binner.sv */
// Bin computation: difference and multiply stage, then index shift and range check.
module wha_binner import wha_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  logic               in_valid,
    input  logic               in_opcode,
    input  logic [VALUE_W-1:0] in_sample,
    input  logic [VALUE_W-1:0] in_weight,
    input  logic [BIN_W-1:0]   in_read_index,
    input  logic [VALUE_W-1:0] range_minimum,
    input  logic [VALUE_W-1:0] inverse_bin_width,
    input  logic [COUNT_W-1:0] bins_in_use,
    output logic               req_valid,
    output bin_req_t           req
);

    logic [VALUE_W:0]   diff;
    logic               reject_next;
    logic [PROD_W-1:0]  prod_next;

    logic               s1_valid_reg;
    logic               s1_opcode_reg;
    logic               s1_reject_reg;
    logic [PROD_W-1:0]  s1_prod_reg;
    logic [VALUE_W-1:0] s1_weight_reg;
    logic [BIN_W-1:0]   s1_read_index_reg;

    logic [PROD_W-1:0]  idx_wide;
    logic [COUNT_W-1:0] active;
    logic               acc_hit;
    logic               rd_hit;

    assign diff        = {in_sample[VALUE_W-1], in_sample}
                       - {range_minimum[VALUE_W-1], range_minimum};
    assign reject_next = diff[VALUE_W] && (inverse_bin_width != '0);
    assign prod_next   = PROD_W'(diff[VALUE_W-1:0]) * PROD_W'(inverse_bin_width);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_opcode_reg     <= in_opcode;
            s1_reject_reg     <= reject_next;
            s1_prod_reg       <= prod_next;
            s1_weight_reg     <= in_weight;
            s1_read_index_reg <= in_read_index;
        end
    end

    assign idx_wide = s1_prod_reg >> (2 * FRAC_BITS);
    assign active   = (bins_in_use > COUNT_W'(MAX_BINS)) ? COUNT_W'(MAX_BINS) : bins_in_use;
    assign acc_hit  = !s1_reject_reg && (idx_wide < PROD_W'(active));
    assign rd_hit   = {1'b0, s1_read_index_reg} < active;

    always_comb begin
        req_valid  = s1_valid_reg;
        req.opcode = s1_opcode_reg;
        req.weight = s1_weight_reg;
        req.status = STATUS_OK;
        req.bin    = '0;
        if (s1_opcode_reg == OP_READ) begin
            if (rd_hit) begin
                req.bin = s1_read_index_reg;
            end else begin
                req.status = STATUS_BAD_INDEX;
            end
        end else begin
            if (acc_hit) begin
                req.bin = idx_wide[BIN_W-1:0];
            end else begin
                req.status = STATUS_DROPPED;
            end
        end
    end

endmodule

/* design/wha_store.sv */
// Bin total memory with read-modify-write, write forwarding and saturating add.
`include "weighted_histogram_accumulator_top_assert.svh"
module wha_store import wha_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        adv,
    input  logic        req_valid,
    input  bin_req_t    req,
    output logic        res_valid,
    output bin_result_t res
);

    logic [TOTAL_W-1:0]        mem [MAX_BINS];
    logic [MAX_BINS-1:0]       seen_reg;
    logic                      p3_valid_reg;
    bin_req_t                  p3_req_reg;
    logic [TOTAL_W-1:0]        mem_rd_reg;
    logic                      rd_seen_reg;
    logic                      last_wr_valid_reg;
    logic [BIN_W-1:0]          last_wr_bin_reg;
    logic [TOTAL_W-1:0]        last_wr_total_reg;

    logic [TOTAL_W-1:0]        old_total;
    logic [TOTAL_W:0]          sum;
    logic [TOTAL_W-1:0]        sum_sat;
    logic                      wr_en;

    assign old_total = (last_wr_valid_reg && (last_wr_bin_reg == p3_req_reg.bin))
                     ? last_wr_total_reg
                     : (rd_seen_reg ? mem_rd_reg : '0);

    assign sum = {old_total[TOTAL_W-1], old_total}
               + {{(TOTAL_W + 1 - VALUE_W){p3_req_reg.weight[VALUE_W-1]}}, p3_req_reg.weight};

    always_comb begin
        if (sum[TOTAL_W] != sum[TOTAL_W-1]) begin
            sum_sat = sum[TOTAL_W] ? {1'b1, {(TOTAL_W-1){1'b0}}}
                                   : {1'b0, {(TOTAL_W-1){1'b1}}};
        end else begin
            sum_sat = sum[TOTAL_W-1:0];
        end
    end

    assign wr_en = adv && p3_valid_reg && (p3_req_reg.opcode == OP_ACCUMULATE)
                 && (p3_req_reg.status == STATUS_OK);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_valid_reg      <= 1'b0;
            seen_reg          <= '0;
            last_wr_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                p3_valid_reg <= req_valid;
            end
            if (wr_en) begin
                seen_reg[p3_req_reg.bin] <= 1'b1;
                last_wr_valid_reg        <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p3_req_reg  <= req;
            mem_rd_reg  <= mem[req.bin];
            rd_seen_reg <= seen_reg[req.bin];
        end
        if (wr_en) begin
            mem[p3_req_reg.bin] <= sum_sat;
            last_wr_bin_reg     <= p3_req_reg.bin;
            last_wr_total_reg   <= sum_sat;
        end
    end

    always_comb begin
        res_valid  = p3_valid_reg;
        res.status = p3_req_reg.status;
        res.bin    = p3_req_reg.bin;
        if (p3_req_reg.status != STATUS_OK) begin
            res.total = '0;
        end else if (p3_req_reg.opcode == OP_ACCUMULATE) begin
            res.total = sum_sat;
        end else begin
            res.total = old_total;
        end
    end

    `WHA_ASSERT_NEXT(a_wr_forward, aclk, aresetn, wr_en, last_wr_valid_reg && (last_wr_bin_reg == $past(p3_req_reg.bin)))
    `WHA_ASSERT_IMPLY(a_drop_is_acc, aclk, aresetn, p3_valid_reg && (p3_req_reg.status == STATUS_DROPPED), p3_req_reg.opcode == OP_ACCUMULATE)

endmodule

/* design/weighted_histogram_accumulator_top.sv */
// Weighted histogram accumulator: 256 saturating 48-bit bins of Q32.16 totals.
// One input transaction is taken every clock cycle when the result side does not
// stall, and each one yields exactly one result transaction after it is accepted,
// passing through input register, 32x32 multiply stage, index check with bin memory
// read, then saturating add and write-back into the result register. A write to a
// bin that the next transaction reads is forwarded, so repeated bins run at full
// rate. Bin totals read as zero after reset through per-bin valid bits, so no
// clearing pass is needed. Configuration writes are taken at any time but must
// only be issued while no transaction is in flight.
`include "weighted_histogram_accumulator_top_assert.svh"
module weighted_histogram_accumulator_top import wha_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [VALUE_W-1:0]     cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // Fields from bit 0: sample[31:0], weight[63:32], read_index[71:64].
    input  logic [71:0]            s_tdata,
    // Fields from bit 0: opcode[0].
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // Fields from bit 0: bin_number[7:0], bin_total[55:8].
    output logic [55:0]            m_tdata,
    // Fields from bit 0: status[1:0].
    output logic [1:0]             m_tuser
);

    logic [VALUE_W-1:0] range_minimum_reg;
    logic [VALUE_W-1:0] inverse_bin_width_reg;
    logic [COUNT_W-1:0] bins_in_use_reg;

    logic               in_valid_reg;
    logic               in_opcode_reg;
    logic [VALUE_W-1:0] in_sample_reg;
    logic [VALUE_W-1:0] in_weight_reg;
    logic [BIN_W-1:0]   in_read_index_reg;

    logic               m_valid_reg;
    logic [55:0]        m_data_reg;
    status_t            m_status_reg;

    logic               adv;
    logic               req_valid;
    bin_req_t           req;
    logic               res_valid;
    bin_result_t        res;

    assign adv       = !m_valid_reg || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_minimum_reg     <= '0;
            inverse_bin_width_reg <= 32'd65536;
            bins_in_use_reg       <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_RANGE_MINIMUM:     range_minimum_reg     <= cfg_data;
                CFG_INVERSE_BIN_WIDTH: inverse_bin_width_reg <= cfg_data;
                CFG_BINS_IN_USE:       bins_in_use_reg       <= cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            in_valid_reg <= s_tvalid;
            m_valid_reg  <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_opcode_reg     <= s_tuser;
            in_sample_reg     <= s_tdata[31:0];
            in_weight_reg     <= s_tdata[63:32];
            in_read_index_reg <= s_tdata[71:64];
            m_data_reg        <= {res.total, res.bin};
            m_status_reg      <= res.status;
        end
    end

    wha_binner #(
        .FRAC_BITS (FRAC_BITS)
    ) u_binner (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .adv               (adv),
        .in_valid          (in_valid_reg),
        .in_opcode         (in_opcode_reg),
        .in_sample         (in_sample_reg),
        .in_weight         (in_weight_reg),
        .in_read_index     (in_read_index_reg),
        .range_minimum     (range_minimum_reg),
        .inverse_bin_width (inverse_bin_width_reg),
        .bins_in_use       (bins_in_use_reg),
        .req_valid         (req_valid),
        .req               (req)
    );

    wha_store u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .req_valid (req_valid),
        .req       (req),
        .res_valid (res_valid),
        .res       (res)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

    `WHA_ASSERT_IMPLY(a_error_zero, aclk, aresetn, m_valid_reg && (m_status_reg != STATUS_OK), m_data_reg == '0)
    `WHA_ASSERT_NEXT(a_accept_loads, aclk, aresetn, s_tvalid && adv, in_valid_reg)

endmodule

/* sim/tb_weighted_histogram_accumulator_top.sv */
// Self-checking testbench for the weighted histogram accumulator top level.
module tb_weighted_histogram_accumulator_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wha_pkg::*;

    localparam int FRAC_BITS      = 16;
    localparam int CLOCK_HALF     = 4;
    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 8;
    localparam int CYCLE_LIMIT    = 50_000;
    localparam int REPORT_LIMIT   = 10;
    localparam int REPEAT_ITEMS   = 16;
    localparam int PHASE_ITEMS    = 100;
    localparam int HOLD_CYCLES    = 300;
    localparam cfg_index_t CFG_UNUSED_INDEX = 2'd3;
    localparam logic signed [48:0] TOTAL_HIGH = 49'sh7FFF_FFFF_FFFF;
    localparam logic signed [48:0] TOTAL_LOW  = -TOTAL_HIGH - 49'sd1;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [VALUE_W-1:0]     cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [71:0]            s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [55:0]            m_tdata;
    logic [1:0]             m_tuser;

    logic [31:0]                hist_range_min = 32'd0;
    logic [31:0]                hist_inv_width = 32'd65536;
    logic [8:0]                 hist_bin_count = 9'd0;
    logic signed [TOTAL_W-1:0]  hist_totals [0:MAX_BINS-1];
    bin_result_t                pending_results [$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int sink_hold      = 0;

    int cycle_count       = 0;
    int mismatches        = 0;
    int items_taken       = 0;
    int ok_results        = 0;
    int dropped_results   = 0;
    int bad_index_results = 0;
    int reg_writes        = 0;
    int saturated_updates = 0;

    weighted_histogram_accumulator_top #(
        .FRAC_BITS(FRAC_BITS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #CLOCK_HALF aclk = ~aclk;

    initial begin
        for (int k = 0; k < MAX_BINS; k++) begin
            hist_totals[k] = '0;
        end
    end

    function automatic int unsigned active_bin_count();
        return (hist_bin_count > MAX_BINS) ? MAX_BINS : hist_bin_count;
    endfunction

    function automatic bin_result_t predict_bin_result(logic op, logic [31:0] smp,
                                                       logic signed [31:0] wgt,
                                                       logic [7:0] idx);
        bin_result_t      res;
        logic signed [32:0] offset;
        logic [63:0]      scaled;
        logic [63:0]      slot;
        logic signed [48:0] sum;
        res = '0;
        res.status = STATUS_OK;
        if (op == OP_ACCUMULATE) begin
            offset = $signed({smp[31], smp}) - $signed({hist_range_min[31], hist_range_min});
            if (offset < 0) begin
                slot = (hist_inv_width == '0) ? 64'd0 : '1;
            end else begin
                scaled = {32'd0, offset[31:0]} * {32'd0, hist_inv_width};
                slot = scaled >> (2 * FRAC_BITS);
            end
            if (slot >= 64'(active_bin_count())) begin
                res.status = STATUS_DROPPED;
                return res;
            end
            sum = hist_totals[slot[7:0]] + wgt;
            if (sum > TOTAL_HIGH) begin
                sum = TOTAL_HIGH;
                saturated_updates++;
            end else if (sum < TOTAL_LOW) begin
                sum = TOTAL_LOW;
                saturated_updates++;
            end
            hist_totals[slot[7:0]] = sum[47:0];
            res.bin = slot[7:0];
            res.total = sum[47:0];
        end else if (idx >= active_bin_count()) begin
            res.status = STATUS_BAD_INDEX;
        end else begin
            res.bin = idx;
            res.total = hist_totals[idx];
        end
        return res;
    endfunction

    task automatic note_mismatch(string text);
        if (mismatches < REPORT_LIMIT) begin
            $display("Mismatch at cycle %0d: %s", cycle_count, text);
        end
        mismatches++;
    endtask

    // Monitor: register writes, accepted items and results, all sampled at the rising edge.
    always @(posedge aclk) begin
        bin_result_t seen;
        bin_result_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_results.size());
            $display("FAIL weighted_histogram_accumulator_top");
            $finish;
        end else if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_RANGE_MINIMUM:     hist_range_min = cfg_data;
                    CFG_INVERSE_BIN_WIDTH: hist_inv_width = cfg_data;
                    CFG_BINS_IN_USE:       hist_bin_count = cfg_data[8:0];
                    default: ;
                endcase
                reg_writes++;
            end
            if (s_tvalid && s_tready) begin
                want = predict_bin_result(s_tuser, s_tdata[31:0], s_tdata[63:32],
                                          s_tdata[71:64]);
                pending_results.push_back(want);
                items_taken++;
                case (want.status)
                    STATUS_OK:      ok_results++;
                    STATUS_DROPPED: dropped_results++;
                    default:        bad_index_results++;
                endcase
            end
            if (m_tvalid && m_tready) begin
                seen.status = m_tuser;
                seen.bin = m_tdata[7:0];
                seen.total = m_tdata[55:8];
                if (pending_results.size() == 0) begin
                    note_mismatch($sformatf("unexpected result status %0d bin %0d total %0d",
                                            seen.status, seen.bin, seen.total));
                end else begin
                    want = pending_results.pop_front();
                    if (seen.status !== want.status || seen.bin !== want.bin ||
                        seen.total !== want.total) begin
                        note_mismatch($sformatf(
                            "expected status %0d bin %0d total %0d, got %0d %0d %0d",
                            want.status, want.bin, want.total,
                            seen.status, seen.bin, seen.total));
                    end
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (sink_hold != 0) begin
            sink_hold = sink_hold - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic send_item(input logic op, input logic [31:0] smp,
                             input logic [31:0] wgt, input logic [7:0] idx);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {idx, wgt, smp};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_acc(input logic [31:0] smp, input logic [31:0] wgt);
        send_item(OP_ACCUMULATE, smp, wgt, 8'($urandom_range(255)));
    endtask

    task automatic send_read(input logic [7:0] idx);
        send_item(OP_READ, $urandom, $urandom, idx);
    endtask

    task automatic quiesce();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] data);
        quiesce();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [31:0] min_val, input logic [31:0] inv_val,
                             input logic [31:0] bins_val);
        write_reg(CFG_RANGE_MINIMUM, min_val);
        write_reg(CFG_INVERSE_BIN_WIDTH, inv_val);
        write_reg(CFG_BINS_IN_USE, bins_val);
    endtask

    task automatic set_idling(input int src_pct, input int sink_pct);
        @(posedge aclk);
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    function automatic logic [31:0] pick_sample();
        logic [63:0]        span;
        logic [63:0]        ofs;
        logic signed [31:0] low_edge;
        logic signed [63:0] pos;
        int unsigned        pick;
        pick = $urandom_range(9);
        if (pick == 0) return $urandom;
        if (pick == 1) return hist_range_min + 32'($urandom_range(8)) - 32'd4;
        if (hist_inv_width == '0) begin
            span = 64'h1_0000_0000;
        end else begin
            span = (64'(active_bin_count()) << 32) / {32'd0, hist_inv_width};
        end
        ofs = {$urandom, $urandom} % (span + (span >> 3) + 64'd1);
        low_edge = hist_range_min;
        pos = low_edge;
        pos = pos + $signed(ofs);
        if (pos > 64'sd2147483647) return $urandom;
        return pos[31:0];
    endfunction

    function automatic logic [31:0] pick_weight();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return w;
            default: return {{12{w[19]}}, w[19:0]};
        endcase
    endfunction

    function automatic logic [7:0] pick_index();
        int unsigned active;
        active = active_bin_count();
        if (active != 0 && $urandom_range(99) < 80) return 8'($urandom_range(active - 1));
        return 8'($urandom_range(255));
    endfunction

    task automatic send_random_item();
        logic op;
        op = ($urandom_range(99) < 25) ? OP_READ : OP_ACCUMULATE;
        send_item(op, pick_sample(), pick_weight(), pick_index());
    endtask

    task automatic test_no_active_bins();
        send_acc(32'd0, 32'h0001_0000);
        send_read(8'd0);
        send_read(8'd255);
    endtask

    task automatic test_bin_edges();
        configure(32'd0, 32'h0001_0000, 32'd8);
        send_acc(32'h0000_0000, 32'h0001_0000);
        send_acc(32'h0007_FFFF, 32'hFFFF_8000);
        send_acc(32'h0008_0000, 32'h0001_0000);
        send_acc(32'hFFFF_FFFF, 32'h0001_0000);
        send_acc(32'h8000_0000, 32'h0001_0000);
        send_acc(32'h7FFF_FFFF, 32'h0001_0000);
        send_item(OP_ACCUMULATE, 32'h0003_0000, 32'h7FFF_FFFF, 8'hFF);
        send_read(8'd0);
        send_read(8'd7);
        send_read(8'd8);
        send_read(8'd255);
    endtask

    task automatic test_zero_width();
        configure(32'h0001_0000, 32'd0, 32'd4);
        send_acc(32'h8000_0000, 32'h8000_0000);
        send_acc(32'h7FFF_FFFF, 32'h0000_0001);
        send_read(8'd0);
        write_reg(CFG_BINS_IN_USE, 32'd0);
        send_acc(32'h0001_0000, 32'h0001_0000);
    endtask

    task automatic test_extreme_scaling();
        configure(32'h8000_0000, 32'hFFFF_FFFF, 32'd256);
        send_acc(32'h8000_0000, 32'h0000_0100);
        send_acc(32'h8000_0001, 32'h0000_0100);
        send_acc(32'h8000_0002, 32'hFFFF_FF00);
        send_acc(32'h7FFF_FFFF, 32'h0000_0100);
        send_read(8'd255);
    endtask

    task automatic test_bin_count_limit();
        write_reg(CFG_BINS_IN_USE, 32'h0000_01FF);
        send_read(8'd255);
        write_reg(CFG_BINS_IN_USE, 32'hFFFF_FE05);
        send_read(8'd4);
        send_read(8'd5);
        write_reg(CFG_BINS_IN_USE, 32'd256);
        send_read(8'd255);
    endtask

    task automatic test_unused_register();
        write_reg(CFG_BINS_IN_USE, 32'd5);
        write_reg(CFG_UNUSED_INDEX, 32'hFFFF_FFFF);
        send_read(8'd4);
        send_read(8'd5);
    endtask

    task automatic test_repeated_bin();
        configure(32'd0, 32'h0001_0000, 32'd2);
        set_idling(0, 0);
        for (int k = 0; k < REPEAT_ITEMS; k++) begin
            send_acc(32'h0000_0000, 32'h7FFF_FFFF);
        end
        for (int k = 0; k < REPEAT_ITEMS; k++) begin
            send_acc(32'h0001_0000, 32'h8000_0000);
        end
        for (int k = 0; k < REPEAT_ITEMS; k++) begin
            send_acc({15'd0, k[0], 16'd0}, pick_weight());
        end
        send_read(8'd0);
        send_read(8'd1);
    endtask

    task automatic test_backpressure();
        configure(32'd0, 32'h0001_0000, 32'd4);
        set_idling(0, 0);
        @(posedge aclk);
        sink_hold = HOLD_CYCLES;
        repeat (60) send_random_item();
    endtask

    task automatic run_random_phase(input int src_pct, input int sink_pct,
                                    input logic [31:0] min_val, input logic [31:0] inv_val,
                                    input logic [31:0] bins_val);
        configure(min_val, inv_val, bins_val);
        set_idling(src_pct, sink_pct);
        repeat (PHASE_ITEMS) send_random_item();
    endtask

    task automatic test_random_traffic();
        logic [31:0] r;
        r = $urandom;
        run_random_phase(0, 0, {{12{r[19]}}, r[19:0]}, 32'h0001_0000, 32'd4);
        run_random_phase(71, 0, $urandom, $urandom, 32'd256);
        run_random_phase(0, 71, 32'h8000_0000, 32'h0000_0100, 32'd200);
        run_random_phase(20, 20, 32'hFFF8_0000, 32'h0004_0000, 32'd16);
        run_random_phase(0, 0, $urandom, 32'd0, 32'd1);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_no_active_bins();
        test_bin_edges();
        test_zero_width();
        test_extreme_scaling();
        test_bin_count_limit();
        test_unused_register();
        test_repeated_bin();
        test_backpressure();
        test_random_traffic();
        quiesce();
        $display("Run covered %0d transactions: %0d binned or read, %0d dropped, %0d bad reads.",
                 items_taken, ok_results, dropped_results, bad_index_results);
        $display("Register writes: %0d, saturated updates: %0d, mismatches: %0d.",
                 reg_writes, saturated_updates, mismatches);
        if (mismatches == 0) begin
            $display("PASS weighted_histogram_accumulator_top");
        end else begin
            $display("FAIL weighted_histogram_accumulator_top");
        end
        $finish;
    end

endmodule

/* weighted_histogram_accumulator_top.f */
+incdir+design
design/wha_pkg.sv
design/wha_binner.sv
design/wha_store.sv
design/weighted_histogram_accumulator_top.sv
sim/tb_weighted_histogram_accumulator_top.sv
